### hdl/qrs_pkg.sv
// ============================================================================
// qrs_pkg
// Shared types, constants and helper functions of the QRS peak detector.
// ============================================================================
package qrs_pkg;

    // Sizes of the stores.
    localparam int PEAK_RING_DEPTH  = 128;
    localparam int RR_HISTORY_DEPTH = 8;
    localparam int PEAK_AW          = $clog2(PEAK_RING_DEPTH);
    localparam int STEP_W           = $clog2(PEAK_RING_DEPTH + 1);
    localparam int HIST_AW          = $clog2(RR_HISTORY_DEPTH);
    localparam int FILL_W           = $clog2(RR_HISTORY_DEPTH + 1);

    // Field widths.
    localparam int SAMPLE_W     = 16;
    localparam int TIME_W       = 32;
    localparam int RR_W         = 16;
    localparam int LEVEL_W      = 16;
    localparam int OUTCOME_W    = 2;
    localparam int PEAK_ENTRY_W = SAMPLE_W + TIME_W;
    localparam int SUM_W        = RR_W + FILL_W;

    // Sequential divider: dividend and divisor widths.
    localparam int DIV_NW = 24;
    localparam int DIV_DW = 8;
    localparam int BND_K_W = 8;

    // Bound scaling: the division by 100 is a multiplication by the rounded-up
    // reciprocal 2^31/100 followed by a shift of 31. This is exact for every
    // product of a 16-bit average and a factor of at most 166.
    localparam int BND_RECIP_W = 25;
    localparam int BND_SHIFT   = 31;
    localparam int BND_PROD_W  = DIV_NW + BND_RECIP_W;
    localparam int BND_Q_W     = BND_PROD_W - BND_SHIFT;
    localparam logic [BND_RECIP_W-1:0] BND_RECIP = 25'd21474837;

    // Configuration port.
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;
    localparam int CFG_NUM = 7;
    localparam int CFG_IW  = 3;

    localparam logic [CFG_IW-1:0] CFG_INIT_SIGNAL   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_INIT_NOISE    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_INIT_THR_HIGH = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_INIT_THR_LOW  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_INIT_RR_LOW   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_INIT_RR_HIGH  = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_INIT_RR_MISS  = 3'd6;

    // Outcome codes.
    localparam logic [OUTCOME_W-1:0] OUTC_NONE   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTC_RPEAK  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTC_SEARCH = 2'd2;

    // Bound index codes.
    localparam logic [1:0] BND_LOW  = 2'd0;
    localparam logic [1:0] BND_HIGH = 2'd1;
    localparam logic [1:0] BND_MISS = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_SUM,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_MUL,
        ST_BND_GO,
        ST_BND_WAIT,
        ST_RETUNE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_sample;
        logic eval;
        logic search;
        logic sum;
        logic avg_go;
        logic avg_wait;
        logic mul;
        logic bnd_go;
        logic bnd_wait;
        logic retune;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_peak;
        logic above_high;
        logic in_window;
        logic above_miss;
        logic found;
        logic exhausted;
        logic sum_last;
        logic div_done;
        logic bnd_last;
    } t_dp_status;

    typedef struct packed {
        logic              we;
        logic [CFG_IW-1:0] idx;
        logic [15:0]       data;
    } t_cfg_wr;

    function automatic logic [15:0] cfg_reset_value(input logic [CFG_IW-1:0] idx);
        logic [15:0] v;
        unique case (idx)
            CFG_INIT_RR_HIGH: v = 16'hFFFF;
            CFG_INIT_RR_MISS: v = 16'hFFFF;
            default:          v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // (x + 7*level) / 8, truncated.
    function automatic logic [LEVEL_W-1:0] level_update(input logic [SAMPLE_W-1:0] x,
                                                        input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W+2:0] s;
        s = {3'b000, x} + ({level, 3'b000} - {3'b000, level});
        return s[LEVEL_W+2:3];
    endfunction

    function automatic logic [BND_K_W-1:0] bnd_factor(input logic [1:0] idx);
        logic [BND_K_W-1:0] k;
        case (idx)
            BND_LOW:  k = 8'd92;
            BND_HIGH: k = 8'd116;
            BND_MISS: k = 8'd166;
            default:  k = 8'd0;
        endcase
        return k;
    endfunction

endpackage

### hdl/qrs_ram.sv
// ============================================================================
// qrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module qrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/qrs_div.sv
// ============================================================================
// qrs_div
// Restoring divider producing one quotient bit per cycle.
// ============================================================================
module qrs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [qrs_pkg::DIV_NW-1:0] i_dividend,
    input  logic [qrs_pkg::DIV_DW-1:0] i_divisor,
    output logic [qrs_pkg::DIV_NW-1:0] o_quotient,
    output logic                       o_done
);
    import qrs_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;
endmodule

### hdl/qrs_ctrl.sv
// ============================================================================
// qrs_ctrl
// Sequencer of the detector: steps the datapath through one word at a time.
// ============================================================================
module qrs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  qrs_pkg::t_dp_status i_status,
    output qrs_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import qrs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid & i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_sample = 1'b1;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_status.is_peak) begin
                    n_state = ST_OUT;
                end else if (!i_status.above_high) begin
                    n_state = ST_RETUNE;
                end else if (i_status.in_window) begin
                    n_state = ST_SUM;
                end else if (i_status.above_miss) begin
                    n_state = ST_SEARCH;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_status.found) begin
                    n_state = ST_SUM;
                end else if (i_status.exhausted) begin
                    n_state = ST_OUT;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                if (i_status.sum_last) begin
                    n_state = ST_AVG_GO;
                end
            end
            ST_AVG_GO: begin
                o_cmd.avg_go = 1'b1;
                n_state = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                o_cmd.avg_wait = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_BND_GO;
            end
            ST_BND_GO: begin
                o_cmd.bnd_go = 1'b1;
                n_state = ST_BND_WAIT;
            end
            ST_BND_WAIT: begin
                o_cmd.bnd_wait = 1'b1;
                n_state = i_status.bnd_last ? ST_RETUNE : ST_MUL;
            end
            ST_RETUNE: begin
                o_cmd.retune = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

### hdl/qrs_dp.sv
// ============================================================================
// qrs_dp
// Datapath: sample window, peak ring, levels, thresholds and RR histories.
// ============================================================================
module qrs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qrs_pkg::t_dp_cmd              i_cmd,
    input  qrs_pkg::t_cfg_wr              i_cfg,
    input  logic [qrs_pkg::SAMPLE_W-1:0]  i_sample,
    output qrs_pkg::t_dp_status           o_status,
    output logic [qrs_pkg::OUTCOME_W-1:0] o_outcome,
    output logic [qrs_pkg::SAMPLE_W-1:0]  o_rpeak_value,
    output logic [qrs_pkg::TIME_W-1:0]    o_rpeak_time,
    output logic [qrs_pkg::RR_W-1:0]      o_rr_interval,
    output logic                          o_warning
);
    import qrs_pkg::*;

    localparam logic [STEP_W-1:0] STEP_END = STEP_W'(PEAK_RING_DEPTH);

    logic [SAMPLE_W-1:0]  r_win [5];
    logic [TIME_W-1:0]    r_clock;
    logic [PEAK_AW-1:0]   r_pos;
    logic [PEAK_RING_DEPTH-1:0] r_valid;
    logic [LEVEL_W-1:0]   r_signal, r_noise, r_thr_high, r_thr_low;
    logic [RR_W-1:0]      r_rr_lo, r_rr_hi, r_rr_miss;
    logic [RR_W-1:0]      r_hist_rec [RR_HISTORY_DEPTH];
    logic [RR_W-1:0]      r_hist_acc [RR_HISTORY_DEPTH];
    logic [HIST_AW-1:0]   r_rec_wr, r_acc_wr;
    logic [FILL_W-1:0]    r_rec_fill, r_acc_fill;
    logic [SAMPLE_W-1:0]  r_rp_value;
    logic [TIME_W-1:0]    r_rp_time;
    logic [RR_W-1:0]      r_latest_rr;
    logic [2:0]           r_miss;
    logic [OUTCOME_W-1:0] r_outcome;
    logic                 r_warn;
    logic [STEP_W-1:0]    r_step;
    logic                 r_rd_live;
    logic                 r_rd_ok;
    logic                 r_hist_sel;   // high: accepted history, low: recent history
    logic [HIST_AW-1:0]   r_k;
    logic [SUM_W-1:0]     r_acc;
    logic [RR_W-1:0]      r_avg;
    logic [DIV_NW-1:0]    r_prod;
    logic [BND_Q_W-1:0]   r_bnd_q;
    logic [1:0]           r_bnd_idx;
    logic [OUTCOME_W-1:0] r_o_outcome;
    logic [SAMPLE_W-1:0]  r_o_rpeak_value;
    logic [TIME_W-1:0]    r_o_rpeak_time;
    logic [RR_W-1:0]      r_o_rr;
    logic                 r_o_warn;

    logic                 is_peak;
    logic [SAMPLE_W-1:0]  pk;
    logic [RR_W-1:0]      rr_now;
    logic [PEAK_AW-1:0]   pos_next;
    logic [STEP_W:0]      pos_ext;
    logic [STEP_W:0]      rd_diff;
    logic [PEAK_AW-1:0]   raddr;
    logic                 rd_en;
    logic                 ram_we;
    logic [PEAK_ENTRY_W-1:0] ram_q;
    logic [SAMPLE_W-1:0]  q_value;
    logic [TIME_W-1:0]    q_time;
    logic                 found;
    logic [FILL_W-1:0]    fill_sel;
    logic [RR_W-1:0]      hist_word;
    logic                 div_start;
    logic [DIV_NW-1:0]    div_dividend;
    logic [DIV_DW-1:0]    div_divisor;
    logic [DIV_NW-1:0]    div_q;
    logic                 div_done;
    logic [BND_PROD_W-1:0] bnd_full;
    logic [LEVEL_W+1:0]   thr_sum;
    logic [2:0]           miss_inc;
    logic [HIST_AW-1:0]   rec_wr_next, acc_wr_next;

    // Peak test on the window: w0 < w1 <= w2 >= w3 > w4.
    assign is_peak = (r_win[0] < r_win[1]) && (r_win[1] <= r_win[2]) &&
                     (r_win[2] >= r_win[3]) && (r_win[3] > r_win[4]);
    assign pk      = r_win[2];
    assign rr_now  = sat16(r_clock - r_rp_time);
    assign pos_next = (r_pos == PEAK_AW'(PEAK_RING_DEPTH - 1)) ? '0 : r_pos + 1'b1;

    // Searchback address: current slot minus step, modulo the ring depth.
    assign pos_ext = (STEP_W + 1)'(r_pos);
    assign rd_diff = (pos_ext >= {1'b0, r_step}) ? pos_ext - {1'b0, r_step}
                   : pos_ext + (STEP_W + 1)'(PEAK_RING_DEPTH) - {1'b0, r_step};
    assign raddr   = rd_diff[PEAK_AW-1:0];
    assign rd_en   = i_cmd.search && (r_step < STEP_END);
    assign ram_we  = i_cmd.eval && is_peak;

    qrs_ram #(
        .WIDTH (PEAK_ENTRY_W),
        .DEPTH (PEAK_RING_DEPTH)
    ) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (pos_next),
        .i_wdata ({pk, r_clock}),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign q_value = ram_q[PEAK_ENTRY_W-1:TIME_W];
    assign q_time  = ram_q[TIME_W-1:0];
    assign found   = r_rd_live && r_rd_ok && (q_value > r_thr_low);

    assign fill_sel  = r_hist_sel ? r_acc_fill : r_rec_fill;
    assign hist_word = r_hist_sel ? r_hist_acc[r_k] : r_hist_rec[r_k];

    // The divider only forms the RR average; bounds use the reciprocal.
    assign div_start    = i_cmd.avg_go;
    assign div_dividend = DIV_NW'(r_acc);
    assign div_divisor  = DIV_DW'(fill_sel);

    qrs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    assign bnd_full = BND_PROD_W'(r_prod) * BND_PROD_W'(BND_RECIP);

    assign thr_sum = {2'b00, r_noise} + {1'b0, r_noise, 1'b0} + {2'b00, r_signal};
    assign miss_inc = r_miss + 3'd1;
    assign rec_wr_next = (r_rec_wr == HIST_AW'(RR_HISTORY_DEPTH - 1)) ? '0 : r_rec_wr + 1'b1;
    assign acc_wr_next = (r_acc_wr == HIST_AW'(RR_HISTORY_DEPTH - 1)) ? '0 : r_acc_wr + 1'b1;

    always_comb begin
        o_status            = '0;
        o_status.is_peak    = is_peak;
        o_status.above_high = (pk > r_thr_high);
        o_status.in_window  = (r_rr_lo < rr_now) && (rr_now < r_rr_hi);
        o_status.above_miss = (rr_now > r_rr_miss);
        o_status.found      = found;
        o_status.exhausted  = !r_rd_live && (r_step == STEP_END);
        o_status.sum_last   = (FILL_W'(r_k) == fill_sel - 1'b1);
        o_status.div_done   = div_done;
        o_status.bnd_last   = (r_bnd_idx == BND_MISS);
    end

    // Control and state that reset defines.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_win[i] <= '0;
            end
            r_clock     <= '0;
            r_pos       <= '0;
            r_valid     <= '0;
            r_signal    <= cfg_reset_value(CFG_INIT_SIGNAL);
            r_noise     <= cfg_reset_value(CFG_INIT_NOISE);
            r_thr_high  <= cfg_reset_value(CFG_INIT_THR_HIGH);
            r_thr_low   <= cfg_reset_value(CFG_INIT_THR_LOW);
            r_rr_lo     <= cfg_reset_value(CFG_INIT_RR_LOW);
            r_rr_hi     <= cfg_reset_value(CFG_INIT_RR_HIGH);
            r_rr_miss   <= cfg_reset_value(CFG_INIT_RR_MISS);
            r_rec_wr    <= '0;
            r_acc_wr    <= '0;
            r_rec_fill  <= '0;
            r_acc_fill  <= '0;
            r_rp_value  <= '0;
            r_rp_time   <= '0;
            r_latest_rr <= '0;
            r_miss      <= '0;
            r_rd_live   <= 1'b0;
        end else begin
            r_rd_live <= rd_en;

            if (i_cfg.we) begin
                case (i_cfg.idx)
                    CFG_INIT_SIGNAL:   r_signal   <= i_cfg.data;
                    CFG_INIT_NOISE:    r_noise    <= i_cfg.data;
                    CFG_INIT_THR_HIGH: r_thr_high <= i_cfg.data;
                    CFG_INIT_THR_LOW:  r_thr_low  <= i_cfg.data;
                    CFG_INIT_RR_LOW:   r_rr_lo    <= i_cfg.data;
                    CFG_INIT_RR_HIGH:  r_rr_hi    <= i_cfg.data;
                    CFG_INIT_RR_MISS:  r_rr_miss  <= i_cfg.data;
                    default: ;
                endcase
            end

            if (i_cmd.load_sample) begin
                for (int i = 4; i > 0; i--) begin
                    r_win[i] <= r_win[i-1];
                end
                r_win[0] <= i_sample;
                r_clock  <= r_clock + 1'b1;
            end

            if (i_cmd.eval && is_peak) begin
                r_pos <= pos_next;
                r_valid[pos_next] <= 1'b1;
                if (pk > r_thr_high) begin
                    r_latest_rr <= rr_now;
                    if ((r_rr_lo < rr_now) && (rr_now < r_rr_hi)) begin
                        r_miss     <= '0;
                        r_rp_value <= pk;
                        r_rp_time  <= r_clock;
                        r_signal   <= level_update(pk, r_signal);
                        r_rec_wr   <= rec_wr_next;
                        r_acc_wr   <= acc_wr_next;
                        if (r_rec_fill != FILL_W'(RR_HISTORY_DEPTH)) begin
                            r_rec_fill <= r_rec_fill + 1'b1;
                        end
                        if (r_acc_fill != FILL_W'(RR_HISTORY_DEPTH)) begin
                            r_acc_fill <= r_acc_fill + 1'b1;
                        end
                    end else begin
                        // Searchback and a plain miss both count as a miss.
                        r_miss <= (miss_inc > 3'd4) ? 3'd0 : miss_inc;
                    end
                end else begin
                    r_noise <= level_update(pk, r_noise);
                end
            end

            if (i_cmd.search && found) begin
                r_rp_value  <= q_value;
                r_rp_time   <= q_time;
                r_latest_rr <= sat16(r_clock - q_time);
                r_signal    <= level_update(pk, r_signal);
                r_rec_wr    <= rec_wr_next;
                if (r_rec_fill != FILL_W'(RR_HISTORY_DEPTH)) begin
                    r_rec_fill <= r_rec_fill + 1'b1;
                end
            end

            if (i_cmd.bnd_wait) begin
                case (r_bnd_idx)
                    BND_LOW:  r_rr_lo   <= sat16(32'(r_bnd_q));
                    BND_HIGH: r_rr_hi   <= sat16(32'(r_bnd_q));
                    BND_MISS: r_rr_miss <= sat16(32'(r_bnd_q));
                    default: ;
                endcase
            end

            if (i_cmd.retune) begin
                r_thr_high <= thr_sum[LEVEL_W+1:2];
                r_thr_low  <= {1'b0, thr_sum[LEVEL_W+1:3]};
            end
        end
    end

    // Working registers of one word; no reset needed.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_ok <= r_valid[raddr];
            r_step  <= r_step + 1'b1;
        end

        if (i_cmd.eval) begin
            r_outcome <= OUTC_NONE;
            r_warn    <= 1'b0;
            r_step    <= STEP_W'(1);
            r_k       <= '0;
            r_acc     <= '0;
            r_hist_sel <= 1'b1;
            if (is_peak && (pk > r_thr_high)) begin
                if ((r_rr_lo < rr_now) && (rr_now < r_rr_hi)) begin
                    r_outcome <= OUTC_RPEAK;
                    r_hist_rec[r_rec_wr] <= rr_now;
                    r_hist_acc[r_acc_wr] <= rr_now;
                end else if (miss_inc > 3'd4) begin
                    r_warn <= 1'b1;
                end
            end
        end

        if (i_cmd.search && found) begin
            r_outcome  <= OUTC_SEARCH;
            r_hist_sel <= 1'b0;
            r_hist_rec[r_rec_wr] <= sat16(q_time - r_rp_time);
        end

        if (i_cmd.sum) begin
            r_acc <= r_acc + SUM_W'(hist_word);
            r_k   <= r_k + 1'b1;
        end

        if (i_cmd.avg_wait && div_done) begin
            r_avg     <= div_q[RR_W-1:0];
            r_bnd_idx <= BND_LOW;
        end

        if (i_cmd.mul) begin
            r_prod <= DIV_NW'(r_avg * bnd_factor(r_bnd_idx));
        end

        if (i_cmd.bnd_go) begin
            r_bnd_q <= bnd_full[BND_PROD_W-1:BND_SHIFT];
        end

        if (i_cmd.bnd_wait) begin
            r_bnd_idx <= r_bnd_idx + 1'b1;
        end

        if (i_cmd.load_out) begin
            r_o_outcome     <= r_outcome;
            r_o_rpeak_value <= r_rp_value;
            r_o_rpeak_time  <= r_rp_time;
            r_o_rr          <= r_latest_rr;
            r_o_warn        <= r_warn;
        end
    end

    assign o_outcome     = r_o_outcome;
    assign o_rpeak_value = r_o_rpeak_value;
    assign o_rpeak_time  = r_o_rpeak_time;
    assign o_rr_interval = r_o_rr;
    assign o_warning     = r_o_warn;
endmodule

### hdl/qrs_peak_detector_core.sv
// ============================================================================
// qrs_peak_detector_core
// QRS (R peak) detector working on filtered, integrated ECG samples.
// ============================================================================
// The core takes one sample word at a time and returns exactly one result word
// for each, in order. A sample that completes no peak goes from EVAL to OUT;
// a peak below the high threshold also passes through RETUNE. An accepted R
// peak adds a sum over the filled RR history (one entry per cycle), one
// division by the fill count on the bit-serial divider, and three bound
// scalings by a reciprocal multiplication (MUL, BND_GO and BND_WAIT each).
// A searchback also walks the peak ring one entry per cycle through the
// single read port of the ring RAM. One word is in work at a time; the
// result sits in an output register, so the next sample is taken while
// the result waits.
module qrs_peak_detector_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [qrs_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [qrs_pkg::OUTCOME_W-1:0] o_outcome,
    output logic [qrs_pkg::SAMPLE_W-1:0]  o_rpeak_value,
    output logic [qrs_pkg::TIME_W-1:0]    o_rpeak_time,
    output logic [qrs_pkg::RR_W-1:0]      o_rr_interval,
    output logic                          o_warning,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qrs_pkg::CFG_AW-1:0]    paddr,
    input  logic [qrs_pkg::CFG_DW-1:0]    pwdata,
    output logic [qrs_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);
    import qrs_pkg::*;

    logic [15:0]       r_cfg [CFG_NUM];
    logic [CFG_IW-1:0] cfg_idx;
    t_cfg_wr           cfg_wr;
    t_dp_cmd           cmd;
    t_dp_status        status;

    // The configuration port never waits. A write goes into the register file
    // that is read back, and also loads the working value in the datapath.
    assign pready       = 1'b1;
    assign cfg_idx      = paddr[CFG_IW+1:2];
    assign cfg_wr.we    = psel && penable && pwrite;
    assign cfg_wr.idx   = cfg_idx;
    assign cfg_wr.data  = pwdata[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= cfg_reset_value(CFG_IW'(i));
            end
        end else if (cfg_wr.we && (cfg_idx < CFG_IW'(CFG_NUM))) begin
            r_cfg[cfg_idx] <= cfg_wr.data;
        end
    end

    // Addresses beyond the last register read as zero.
    always_comb begin
        unique case (cfg_idx)
            CFG_INIT_SIGNAL, CFG_INIT_NOISE, CFG_INIT_THR_HIGH, CFG_INIT_THR_LOW,
            CFG_INIT_RR_LOW, CFG_INIT_RR_HIGH, CFG_INIT_RR_MISS: begin
                prdata = {16'h0000, r_cfg[cfg_idx]};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    qrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    qrs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg_wr),
        .i_sample      (i_sample),
        .o_status      (status),
        .o_outcome     (o_outcome),
        .o_rpeak_value (o_rpeak_value),
        .o_rpeak_time  (o_rpeak_time),
        .o_rr_interval (o_rr_interval),
        .o_warning     (o_warning)
    );

`ifndef SYNTHESIS
    // Only one word is in work: an accepted sample always stalls the input.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a sample was accepted");

    // An accepted R peak clears the miss count, so it never raises the warning.
    a_no_warn_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == OUTC_RPEAK) |-> !o_warning)
        else $error("warning raised together with an accepted R peak");

    // An accepted RR lies strictly above the lower bound, so it is never zero.
    a_rr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == OUTC_RPEAK) |-> (o_rr_interval != '0))
        else $error("accepted R peak with zero RR interval");

    // The outcome code is one of the three defined codes.
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_outcome == OUTC_NONE) || (o_outcome == OUTC_RPEAK) ||
                        (o_outcome == OUTC_SEARCH))
        else $error("undefined outcome code");
`endif
endmodule
